@@ hw/rtl/pcb_pkg.sv @@
// Shared constants, register codes and width helpers for the particle cell binning block.
`timescale 1ns / 1ps
`default_nettype none

package pcb_pkg;

  localparam int DEF_MAX_CELLS = 64;
  localparam int QUEUE_DEPTH = 4;

  // Signed width of a local coordinate after the origin subtract and the wrap.
  localparam int LOC_W = 35;

  localparam logic [30:0] RST_FIELD_SIZE = 31'd16777216;
  localparam logic [31:0] RST_ORIGIN = 32'd0;
  localparam logic [30:0] RST_EXTENT = 31'd16777216;
  localparam logic [30:0] RST_CELL_SIZE = 31'd2097152;
  localparam logic [29:0] RST_RANGE = 30'd524288;
  localparam logic [6:0] RST_CELL_COUNT = 7'd8;

  typedef enum logic [2:0] {
    REG_FIELD_SIZE = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_ORIGIN_Z = 3'd3,
    REG_EXTENT = 3'd4,
    REG_CELL_SIZE = 3'd5,
    REG_RANGE = 3'd6,
    REG_CELL_COUNT = 3'd7
  } cfg_reg_t;

  // Bits needed to hold a cell count up to and including max_cells.
  function automatic int cell_w(input int max_cells);
    return $clog2(max_cells + 1);
  endfunction

  // Width of one queued particle record for a given cell coordinate width.
  function automatic int entry_w(input int nw);
    return 19 + 12 * nw;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pcb_front.sv @@
// Front pipeline: origin subtract, wrap, pipelined cell division, clamp and neighbor selection.
`timescale 1ns / 1ps
`default_nettype none

module pcb_front #(
  parameter int MAX_CELLS_PER_AXIS = pcb_pkg::DEF_MAX_CELLS,
  localparam int NW = pcb_pkg::cell_w(MAX_CELLS_PER_AXIS),
  localparam int EW = pcb_pkg::entry_w(NW)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [15:0]         item_index,
  input  wire logic [31:0]         pos_x,
  input  wire logic [31:0]         pos_y,
  input  wire logic [31:0]         pos_z,
  input  wire logic [30:0]         wrap_len,
  input  wire logic signed [31:0]  origin_x,
  input  wire logic signed [31:0]  origin_y,
  input  wire logic signed [31:0]  origin_z,
  input  wire logic [30:0]         extent_with_margin,
  input  wire logic [30:0]         cell_size,
  input  wire logic [29:0]         near_dist,
  input  wire logic [NW-1:0]       n,
  input  wire logic [2*NW-1:0]     n2,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output logic [EW-1:0]            q_data
);
  import pcb_pkg::*;

  localparam int LW = LOC_W;
  localparam int DW = ((LW > 31 + NW) ? LW : 31 + NW) + 1;

  typedef struct packed {
    logic [15:0]     idx;
    logic [2:0]      mask;
    logic [NW-1:0]   x0;
    logic [NW-1:0]   x1;
    logic [2*NW-1:0] y0;
    logic [2*NW-1:0] y1;
    logic [3*NW-1:0] z0;
    logic [3*NW-1:0] z1;
  } entry_t;

  logic en;

  logic signed [LW-1:0] fs_s;
  logic signed [LW-1:0] ewm_s;
  logic signed [LW-1:0] rng_s;
  logic signed [LW-1:0] csmr_s;
  logic [DW-1:0]        cs_top;
  logic [NW-1:0]        n_m1;

  // Origin subtract.
  logic                 v1;
  logic [15:0]          idx1;
  logic signed [LW-1:0] loc1 [3];

  // Periodic wrap.
  logic                 v2;
  logic [15:0]          idx2;
  logic signed [LW-1:0] loc2 [3];

  // Division stages: stage 0 holds the dividend, stage k+1 has k+1 quotient bits.
  logic                 dv   [0:NW];
  logic [15:0]          didx [0:NW];
  logic [DW-1:0]        drem [0:NW][3];
  logic [NW-1:0]        dq   [0:NW][3];
  logic                 dneg [0:NW][3];
  logic                 dsat [0:NW][3];
  logic signed [LW-1:0] dloc [0:NW][3];

  // Clamp.
  logic                 v4;
  logic [15:0]          idx4;
  logic [NW-1:0]        c4 [3];
  logic signed [LW-1:0] loc4 [3];

  // Cell base product.
  logic                 v5;
  logic [15:0]          idx5;
  logic [NW-1:0]        c5 [3];
  logic signed [LW-1:0] loc5 [3];
  logic [NW+30:0]       prod5 [3];

  // Offset inside the cell.
  logic                 v6;
  logic [15:0]          idx6;
  logic [NW-1:0]        c6 [3];
  logic signed [LW-1:0] off6 [3];

  // Neighbor choice.
  logic                 v7;
  logic [15:0]          idx7;
  logic [NW-1:0]        c7 [3];
  logic [NW-1:0]        nb7 [3];
  logic [2:0]           has7;

  // Record ready for the queue.
  logic                 v8;
  entry_t               ent8;

  logic [31:0]          pos_in [3];
  logic signed [31:0]   org_in [3];

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign org_in[0] = origin_x;
  assign org_in[1] = origin_y;
  assign org_in[2] = origin_z;

  assign fs_s   = LW'($signed({1'b0, wrap_len}));
  assign ewm_s  = LW'($signed({1'b0, extent_with_margin}));
  assign rng_s  = LW'($signed({1'b0, near_dist}));
  assign csmr_s = LW'($signed({1'b0, cell_size})) - rng_s;
  assign cs_top = DW'(cell_size) << NW;
  assign n_m1   = n - NW'(1);

  assign en       = !v8 || q_ready;
  assign in_ready = en;
  assign q_valid  = v8;
  assign q_data   = ent8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      idx1 <= item_index;
      for (int a = 0; a < 3; a++) begin
        loc1[a] <= LW'($signed({1'b0, pos_in[a]})) - LW'(org_in[a]);
      end
      v2 <= v1;
      idx2 <= idx1;
      for (int a = 0; a < 3; a++) begin
        if (loc1[a] > ewm_s) begin
          loc2[a] <= loc1[a] - fs_s;
        end else if (loc1[a][LW-1]) begin
          loc2[a] <= loc1[a] + fs_s;
        end else begin
          loc2[a] <= loc1[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NW; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= v2;
      didx[0] <= idx2;
      for (int a = 0; a < 3; a++) begin
        dloc[0][a] <= loc2[a];
        dneg[0][a] <= loc2[a][LW-1];
        dq[0][a] <= '0;
        if (loc2[a][LW-1]) begin
          drem[0][a] <= '0;
          dsat[0][a] <= 1'b0;
        end else begin
          drem[0][a] <= DW'($unsigned(loc2[a]));
          dsat[0][a] <= DW'($unsigned(loc2[a])) >= cs_top;
        end
      end
      for (int k = 0; k < NW; k++) begin
        dv[k+1] <= dv[k];
        didx[k+1] <= didx[k];
        for (int a = 0; a < 3; a++) begin
          dloc[k+1][a] <= dloc[k][a];
          dneg[k+1][a] <= dneg[k][a];
          dsat[k+1][a] <= dsat[k][a];
          if (drem[k][a] >= (DW'(cell_size) << (NW - 1 - k))) begin
            drem[k+1][a] <= drem[k][a] - (DW'(cell_size) << (NW - 1 - k));
            dq[k+1][a] <= dq[k][a] | (NW'(1) << (NW - 1 - k));
          end else begin
            drem[k+1][a] <= drem[k][a];
            dq[k+1][a] <= dq[k][a];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v4 <= dv[NW];
      idx4 <= didx[NW];
      for (int a = 0; a < 3; a++) begin
        loc4[a] <= dloc[NW][a];
        if (dneg[NW][a]) begin
          c4[a] <= '0;
        end else if (dsat[NW][a] || dq[NW][a] >= n) begin
          c4[a] <= n_m1;
        end else begin
          c4[a] <= dq[NW][a];
        end
      end

      v5 <= v4;
      idx5 <= idx4;
      for (int a = 0; a < 3; a++) begin
        c5[a] <= c4[a];
        loc5[a] <= loc4[a];
        prod5[a] <= (NW+31)'(c4[a]) * (NW+31)'(cell_size);
      end

      v6 <= v5;
      idx6 <= idx5;
      for (int a = 0; a < 3; a++) begin
        c6[a] <= c5[a];
        off6[a] <= loc5[a] - $signed(LW'(prod5[a]));
      end

      v7 <= v6;
      idx7 <= idx6;
      for (int a = 0; a < 3; a++) begin
        c7[a] <= c6[a];
        if (off6[a] <= rng_s) begin
          has7[a] <= 1'b1;
          nb7[a] <= (c6[a] == '0) ? n_m1 : c6[a] - NW'(1);
        end else if (off6[a] >= csmr_s) begin
          has7[a] <= 1'b1;
          nb7[a] <= (c6[a] == n_m1) ? '0 : c6[a] + NW'(1);
        end else begin
          has7[a] <= 1'b0;
          nb7[a] <= '0;
        end
      end

      v8 <= v7;
      ent8.idx <= idx7;
      ent8.mask <= {has7[0], has7[1], has7[2]};
      ent8.x0 <= c7[0];
      ent8.x1 <= nb7[0];
      ent8.y0 <= (2*NW)'(c7[1]) * (2*NW)'(n);
      ent8.y1 <= (2*NW)'(nb7[1]) * (2*NW)'(n);
      ent8.z0 <= (3*NW)'(c7[2]) * (3*NW)'(n2);
      ent8.z1 <= (3*NW)'(nb7[2]) * (3*NW)'(n2);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pcb_queue.sv @@
// Small register queue that decouples the front pipeline from the result sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pcb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcb_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  import pcb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + CW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pcb_back.sv @@
// Result sequencer: walks each queued particle's cells, one beat per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module pcb_back #(
  parameter int MAX_CELLS_PER_AXIS = pcb_pkg::DEF_MAX_CELLS,
  localparam int NW = pcb_pkg::cell_w(MAX_CELLS_PER_AXIS),
  localparam int EW = pcb_pkg::entry_w(NW)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire logic [EW-1:0] q_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        particle_index,
  output logic [17:0]        cell_index,
  output logic               last_cell
);
  import pcb_pkg::*;

  localparam int SW = (3 * NW + 1 > 18) ? 3 * NW + 1 : 18;

  typedef struct packed {
    logic [15:0]     idx;
    logic [2:0]      mask;
    logic [NW-1:0]   x0;
    logic [NW-1:0]   x1;
    logic [2*NW-1:0] y0;
    logic [2*NW-1:0] y1;
    logic [3*NW-1:0] z0;
    logic [3*NW-1:0] z1;
  } entry_t;

  entry_t        head;
  logic [2:0]    combo;
  logic [2:0]    combo_next;
  logic          take;
  logic          at_last;
  logic [SW-1:0] sum;

  assign head    = entry_t'(q_data);
  assign take    = q_valid && (!out_valid || out_ready);
  assign at_last = combo == head.mask;
  assign q_ready = take && at_last;

  // Combinations are {x, y, z} choice bits; only bits set in the mask may be one.
  always_comb begin
    combo_next = combo;
    if (take) begin
      combo_next = at_last ? 3'd0 : (((combo | ~head.mask) + 3'd1) & head.mask);
    end
  end

  assign sum = SW'(combo[2] ? head.x1 : head.x0)
             + SW'(combo[1] ? head.y1 : head.y0)
             + SW'(combo[0] ? head.z1 : head.z0);

  always_ff @(posedge clk) begin
    if (rst) begin
      combo <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      combo <= combo_next;
      if (!out_valid || out_ready) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      particle_index <= head.idx;
      cell_index <= sum[17:0];
      last_cell <= at_last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/particle_cell_binning_with_overlap.sv @@
// Top level of the particle cell binning block with neighbor cell overlap.
// A particle passes the front pipeline, the queue and the registered result sequencer.
// Throughput: one particle per cycle enters the front pipeline unless it is stalled;
// each particle then gives one to eight beats on the result channel, one per cell,
// which sets the rate. Reset is synchronous: the configuration registers return to
// their defaults and all pipelines empty.
`timescale 1ns / 1ps
`default_nettype none

module particle_cell_binning_with_overlap #(
  parameter int MAX_CELLS_PER_AXIS = pcb_pkg::DEF_MAX_CELLS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire pcb_pkg::cfg_reg_t cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [15:0]       item_index,
  input  wire logic [31:0]       pos_x,
  input  wire logic [31:0]       pos_y,
  input  wire logic [31:0]       pos_z,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            particle_index,
  output logic [17:0]            cell_index,
  output logic                   last_cell
);
  import pcb_pkg::*;

  localparam int NW = cell_w(MAX_CELLS_PER_AXIS);
  localparam int EW = entry_w(NW);

  logic [30:0]        wrap_len;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic [30:0]        extent_with_margin;
  logic [30:0]        cell_size;
  logic [29:0]        near_dist;
  logic [6:0]         cells_per_axis;

  logic [15:0]        n_wide;
  logic [15:0]        n_sat;
  logic [NW-1:0]      n_eff;
  logic [2*NW-1:0]    n_sq;

  logic               fq_valid;
  logic               fq_ready;
  logic [EW-1:0]      fq_data;
  logic               qb_valid;
  logic               qb_ready;
  logic [EW-1:0]      qb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_len <= RST_FIELD_SIZE;
      origin_x <= RST_ORIGIN;
      origin_y <= RST_ORIGIN;
      origin_z <= RST_ORIGIN;
      extent_with_margin <= RST_EXTENT;
      cell_size <= RST_CELL_SIZE;
      near_dist <= RST_RANGE;
      cells_per_axis <= RST_CELL_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIELD_SIZE: wrap_len <= cfg_data[30:0];
        REG_ORIGIN_X:   origin_x <= cfg_data;
        REG_ORIGIN_Y:   origin_y <= cfg_data;
        REG_ORIGIN_Z:   origin_z <= cfg_data;
        REG_EXTENT:     extent_with_margin <= cfg_data[30:0];
        REG_CELL_SIZE:  cell_size <= cfg_data[30:0];
        REG_RANGE:      near_dist <= cfg_data[29:0];
        REG_CELL_COUNT: cells_per_axis <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // A cell count of zero acts as one, and counts above the maximum saturate.
  assign n_wide = 16'(cells_per_axis);

  always_comb begin
    if (n_wide == '0) begin
      n_sat = 16'd1;
    end else if (n_wide > 16'(MAX_CELLS_PER_AXIS)) begin
      n_sat = 16'(MAX_CELLS_PER_AXIS);
    end else begin
      n_sat = n_wide;
    end
  end

  always_ff @(posedge clk) begin
    n_eff <= n_sat[NW-1:0];
    n_sq <= (2*NW)'(n_eff) * (2*NW)'(n_eff);
  end

  pcb_front #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .item_index(item_index),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .wrap_len(wrap_len),
    .origin_x(origin_x),
    .origin_y(origin_y),
    .origin_z(origin_z),
    .extent_with_margin(extent_with_margin),
    .cell_size(cell_size),
    .near_dist(near_dist),
    .n(n_eff),
    .n2(n_sq),
    .q_valid(fq_valid),
    .q_ready(fq_ready),
    .q_data(fq_data)
  );

  pcb_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data(fq_data),
    .pop_valid(qb_valid),
    .pop_ready(qb_ready),
    .pop_data(qb_data)
  );

  pcb_back #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(qb_valid),
    .q_ready(qb_ready),
    .q_data(qb_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .particle_index(particle_index),
    .cell_index(cell_index),
    .last_cell(last_cell)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pcb_checker.sv @@
// Port-level checker for the particle cell binning block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] particle_index,
  input wire logic [17:0] cell_index,
  input wire logic        last_cell
);

  logic       in_beat;
  logic       out_beat;
  logic [7:0] pending;
  logic [7:0] pending_next;
  logic       mid;
  logic [15:0] saved_idx;
  logic [2:0] beats;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    pending_next = pending;
    if (in_beat && !(out_beat && last_cell)) begin
      pending_next = pending + 8'd1;
    end else if (!in_beat && out_beat && last_cell) begin
      pending_next = pending - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 8'd0;
      mid <= 1'b0;
      beats <= 3'd0;
    end else begin
      pending <= pending_next;
      if (out_beat) begin
        if (last_cell) begin
          mid <= 1'b0;
          beats <= 3'd0;
        end else begin
          mid <= 1'b1;
          beats <= beats + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      saved_idx <= particle_index;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output beat present right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(particle_index)
      && $stable(cell_index) && $stable(last_cell))
    else $error("Stalled output beat changed.");

  a_same_particle: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid |-> particle_index == saved_idx)
    else $error("Particle index changed inside one group of cell beats.");

  a_eight_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && beats == 3'd7 |-> last_cell)
    else $error("More than eight cell beats for one particle.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("Output beat without an outstanding particle.");

endmodule

bind particle_cell_binning_with_overlap pcb_checker u_pcb_checker (.*);

`default_nettype wire
